>>> rtl/mclc_pkg.sv
package mclc_pkg;

	// default chain limits
	localparam int MAX_LEVELS_DEF    = 32;
	localparam int MAX_DIM_DEF       = 65536;
	localparam int PAYLOAD_LIMIT_DEF = 1073741824;

	// config port
	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	localparam logic [1:0] REG_BPT   = 2'd0;
	localparam logic [1:0] REG_BLOCK = 2'd1;
	localparam logic [1:0] REG_IS3D  = 2'd2;

	localparam logic [4:0] BPT_RST   = 5'd4;
	localparam logic [4:0] BLOCK_RST = 5'd0;
	localparam logic       IS3D_RST  = 1'b0;

	// status codes
	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_LEVELS = 3'd1;
	localparam logic [2:0] ST_DIM    = 3'd2;
	localparam logic [2:0] ST_HALVE  = 3'd3;
	localparam logic [2:0] ST_FORMAT = 3'd4;
	localparam logic [2:0] ST_LIMIT  = 3'd5;
	localparam logic [2:0] ST_RANGE  = 3'd6;
	localparam logic [2:0] ST_TOTAL  = 3'd7;

	typedef struct packed {
		logic [4:0] bpt;
		logic [4:0] block;
		logic       is_3d;
	} cfg_t;

	// halve, never below one
	function automatic logic [16:0] half_one(input logic [16:0] v);
		logic [16:0] h;
		h = {1'b0, v[16:1]};
		half_one = (h == 17'd0) ? 17'd1 : h;
	endfunction

	// 4x4 block count along one axis, at least one
	function automatic logic [15:0] blocks_of(input logic [16:0] v);
		logic [17:0] s;
		s = {1'b0, v} + 18'd3;
		blocks_of = (s[17:2] == 16'd0) ? 16'd1 : s[17:2];
	endfunction

endpackage

>>> rtl/mclc_if.sv
interface mclc_level_if;
	logic        valid;
	logic        ready;
	logic [31:0] level_width;
	logic [31:0] level_height;
	logic [31:0] level_depth;
	logic [63:0] level_offset;
	logic [63:0] level_bytes;
	logic [63:0] level_row_pitch;
	logic [63:0] level_slice_pitch;
	logic [63:0] total_payload_bytes;
	logic        last_level;

	modport source(
		output valid, level_width, level_height, level_depth, level_offset,
			level_bytes, level_row_pitch, level_slice_pitch, total_payload_bytes,
			last_level,
		input ready
	);
	modport sink(
		input valid, level_width, level_height, level_depth, level_offset,
			level_bytes, level_row_pitch, level_slice_pitch, total_payload_bytes,
			last_level,
		output ready
	);
endinterface

interface mclc_result_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [4:0]  level_index;
	logic [30:0] next_offset;
	logic        chain_done;

	modport source(output valid, status, level_index, next_offset, chain_done, input ready);
	modport sink(input valid, status, level_index, next_offset, chain_done, output ready);
endinterface

>>> rtl/mclc_cfg_regs.sv
module mclc_cfg_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mclc_pkg::ADDR_W-1:0] paddr,
	input  logic [mclc_pkg::DATA_W-1:0] pwdata,
	output logic [mclc_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	output mclc_pkg::cfg_t              cfg
);

	logic [4:0] bpt_q;
	logic [4:0] block_q;
	logic       is3d_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite & pready;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpt_q   <= mclc_pkg::BPT_RST;
			block_q <= mclc_pkg::BLOCK_RST;
			is3d_q  <= mclc_pkg::IS3D_RST;
		end else if (wr_en) begin
			case (reg_idx)
				mclc_pkg::REG_BPT:   bpt_q   <= pwdata[4:0];
				mclc_pkg::REG_BLOCK: block_q <= pwdata[4:0];
				mclc_pkg::REG_IS3D:  is3d_q  <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			mclc_pkg::REG_BPT:   prdata = {27'd0, bpt_q};
			mclc_pkg::REG_BLOCK: prdata = {27'd0, block_q};
			mclc_pkg::REG_IS3D:  prdata = {31'd0, is3d_q};
			default:             prdata = '0;
		endcase
	end

	assign cfg.bpt   = bpt_q;
	assign cfg.block = block_q;
	assign cfg.is_3d = is3d_q;

endmodule

>>> rtl/mip_chain_layout_checker_top.sv
// mip chain layout checker: takes one level descriptor per transfer on lvl and
// gives one status transfer on res. per level: take the descriptor, make three
// passes through a single shared 31x17 multiplier (row pitch, slice pitch,
// level size), then run the compares and load the result register once res
// has room. a new level is taken only after the last one is done. the result
// register lets the next descriptor in while the last result still waits. the
// first error in a chain sticks for the rest of it; all chain state clears
// after the level marked last. format registers (bytes per texel, bytes per
// 4x4 block, volume flag) sit on the apb port at byte addresses 0, 4 and 8.
// the user must write them only while no level is in flight; unenforced here.
module mip_chain_layout_checker_top #(
	parameter int MAX_LEVELS    = mclc_pkg::MAX_LEVELS_DEF,
	parameter int MAX_DIM       = mclc_pkg::MAX_DIM_DEF,
	parameter int PAYLOAD_LIMIT = mclc_pkg::PAYLOAD_LIMIT_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mclc_pkg::ADDR_W-1:0] paddr,
	input  logic [mclc_pkg::DATA_W-1:0] pwdata,
	output logic [mclc_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	mclc_level_if.sink                  lvl,
	mclc_result_if.source               res
);

	// sequencer states
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_ROW   = 3'd1;
	localparam logic [2:0] S_SLICE = 3'd2;
	localparam logic [2:0] S_SIZE  = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	mclc_pkg::cfg_t cfg;

	mclc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	logic [2:0]  state_q;

	// descriptor held for the whole level
	logic [31:0] w_q;
	logic [31:0] h_q;
	logic [31:0] d_q;
	logic [63:0] off_q;
	logic [63:0] bytes_q;
	logic [63:0] rowp_q;
	logic [63:0] slicep_q;
	logic [63:0] total_q;
	logic        last_q;

	// chain state
	logic [16:0] prev_w_q;
	logic [16:0] prev_h_q;
	logic [16:0] prev_d_q;
	logic [30:0] ro_q;
	logic [5:0]  count_q;
	logic [2:0]  err_q;

	// multiplier results, one per pass
	logic [20:0] row_q;
	logic [37:0] slice_q;
	logic [47:0] size_q;

	// result register
	logic        res_valid_q;
	logic [2:0]  status_q;
	logic [4:0]  index_q;
	logic [30:0] next_off_q;
	logic        done_q;

	logic        in_xfer;
	logic        out_free;
	logic        texel_fmt;
	logic [16:0] rows;
	logic [30:0] mul_a;
	logic [16:0] mul_b;
	logic [47:0] mul_p;

	logic        lv_fail;
	logic        dim_fail;
	logic        halve_fail;
	logic        fmt_fail;
	logic        slice_over;
	logic        size_over;
	logic        range_fail;
	logic [16:0] want_d;
	logic [31:0] ro_sum;
	logic [2:0]  lvl_st;
	logic [2:0]  err_lvl;
	logic [2:0]  err_fin;
	logic        upd;
	logic [30:0] ro_nx;

	assign lvl.ready = (state_q == S_IDLE);
	assign in_xfer   = lvl.valid & lvl.ready;
	assign out_free  = ~res_valid_q | res.ready;
	assign texel_fmt = (cfg.bpt != 5'd0);

	// rows of texels, or rows of blocks when compressed
	assign rows = texel_fmt ? h_q[16:0] : {1'b0, mclc_pkg::blocks_of(h_q[16:0])};

	// shared multiplier operand select
	always_comb begin
		case (state_q)
			S_ROW: begin
				if (texel_fmt) begin
					mul_a = {14'd0, w_q[16:0]};
					mul_b = {12'd0, cfg.bpt};
				end else begin
					mul_a = {15'd0, mclc_pkg::blocks_of(w_q[16:0])};
					mul_b = {12'd0, cfg.block};
				end
			end
			S_SLICE: begin
				mul_a = {10'd0, row_q};
				mul_b = rows;
			end
			S_SIZE: begin
				// slice above the limit fails before size matters
				mul_a = slice_q[30:0];
				mul_b = d_q[16:0];
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = {17'd0, mul_a} * {31'd0, mul_b};

	// level checks, in priority order
	always_comb begin
		lv_fail  = (count_q >= 6'(MAX_LEVELS));
		dim_fail = (w_q == 32'd0) || (h_q == 32'd0) || (d_q == 32'd0) ||
			(w_q > 32'(MAX_DIM)) || (h_q > 32'(MAX_DIM)) || (d_q > 32'(MAX_DIM)) ||
			(!cfg.is_3d && (d_q != 32'd1));
		want_d = cfg.is_3d ? mclc_pkg::half_one(prev_d_q) : 17'd1;
		halve_fail = (count_q != 6'd0) &&
			((w_q != {15'd0, mclc_pkg::half_one(prev_w_q)}) ||
			(h_q != {15'd0, mclc_pkg::half_one(prev_h_q)}) ||
			(d_q != {15'd0, want_d}));
		fmt_fail   = (cfg.bpt == 5'd0) && (cfg.block == 5'd0);
		slice_over = ({10'd0, slice_q} > 48'(PAYLOAD_LIMIT));
		size_over  = (size_q > 48'(PAYLOAD_LIMIT));
		// size is within the limit here, so the low 31 bits carry it
		ro_sum     = {1'b0, ro_q} + {1'b0, size_q[30:0]};
		range_fail = (off_q != {33'd0, ro_q}) || (bytes_q != {16'd0, size_q}) ||
			(rowp_q != {43'd0, row_q}) || (slicep_q != {26'd0, slice_q}) ||
			(ro_sum > 32'(PAYLOAD_LIMIT));

		if (lv_fail)         lvl_st = mclc_pkg::ST_LEVELS;
		else if (dim_fail)   lvl_st = mclc_pkg::ST_DIM;
		else if (halve_fail) lvl_st = mclc_pkg::ST_HALVE;
		else if (fmt_fail)   lvl_st = mclc_pkg::ST_FORMAT;
		else if (slice_over) lvl_st = mclc_pkg::ST_LIMIT;
		else if (size_over)  lvl_st = mclc_pkg::ST_LIMIT;
		else if (range_fail) lvl_st = mclc_pkg::ST_RANGE;
		else                 lvl_st = mclc_pkg::ST_OK;

		// a kept error skips the level entirely
		if (err_q != mclc_pkg::ST_OK) begin
			err_lvl = err_q;
			upd     = 1'b0;
		end else begin
			err_lvl = lvl_st;
			upd     = (lvl_st == mclc_pkg::ST_OK);
		end
		ro_nx = upd ? ro_sum[30:0] : ro_q;

		// closing total check on the last level
		err_fin = err_lvl;
		if (last_q && (err_lvl == mclc_pkg::ST_OK)) begin
			if (total_q > 64'(PAYLOAD_LIMIT))
				err_fin = mclc_pkg::ST_LIMIT;
			else if (total_q != {33'd0, ro_nx})
				err_fin = mclc_pkg::ST_TOTAL;
		end
	end

	// descriptor capture
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			w_q      <= lvl.level_width;
			h_q      <= lvl.level_height;
			d_q      <= lvl.level_depth;
			off_q    <= lvl.level_offset;
			bytes_q  <= lvl.level_bytes;
			rowp_q   <= lvl.level_row_pitch;
			slicep_q <= lvl.level_slice_pitch;
			total_q  <= lvl.total_payload_bytes;
			last_q   <= lvl.last_level;
		end
	end

	// multiplier passes
	always_ff @(posedge clk) begin
		case (state_q)
			S_ROW:   row_q   <= mul_p[20:0];
			S_SLICE: slice_q <= mul_p[37:0];
			S_SIZE:  size_q  <= mul_p;
			default: ;
		endcase
	end

	// sequencer and chain state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			prev_w_q <= '0;
			prev_h_q <= '0;
			prev_d_q <= '0;
			ro_q     <= '0;
			count_q  <= '0;
			err_q    <= mclc_pkg::ST_OK;
		end else begin
			case (state_q)
				S_IDLE:  if (in_xfer) state_q <= S_ROW;
				S_ROW:   state_q <= S_SLICE;
				S_SLICE: state_q <= S_SIZE;
				S_SIZE:  state_q <= S_DONE;
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
						if (last_q) begin
							// chain closes
							prev_w_q <= '0;
							prev_h_q <= '0;
							prev_d_q <= '0;
							ro_q     <= '0;
							count_q  <= '0;
							err_q    <= mclc_pkg::ST_OK;
						end else begin
							err_q <= err_fin;
							ro_q  <= ro_nx;
							if (upd) begin
								prev_w_q <= w_q[16:0];
								prev_h_q <= h_q[16:0];
								prev_d_q <= d_q[16:0];
							end
							if (count_q != 6'h3F)
								count_q <= count_q + 6'd1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if ((state_q == S_DONE) && out_free) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_DONE) && out_free) begin
			status_q   <= err_fin;
			index_q    <= count_q[4:0];
			next_off_q <= ro_nx;
			done_q     <= last_q;
		end
	end

	assign res.valid       = res_valid_q;
	assign res.status      = status_q;
	assign res.level_index = index_q;
	assign res.next_offset = next_off_q;
	assign res.chain_done  = done_q;

endmodule
